[design/koet_pkg.sv]
// ----------------------------------------------------------------------------
// Keyed ordered entry table: shared definitions
// Command codes, field widths and sizing helpers used by the table logic.
// ----------------------------------------------------------------------------
`default_nettype none

package koet_pkg;

    localparam int KOET_DEPTH   = 64;
    localparam int KEY_W        = 8;
    localparam int SCORE_W      = 16;
    localparam int ENTRY_W      = KEY_W + SCORE_W;
    localparam int CMD_W        = 3;
    localparam int POS_W        = 6;
    localparam int CAP_W        = 7;
    localparam int TOTAL_W      = 7;
    localparam int S_DATA_W     = 32;
    localparam int M_DATA_W     = 48;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
    localparam logic [KEY_W-1:0] BLANK_KEY = 8'd32;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd5;

    // Register index of the capacity register (byte address 4 * index).
    localparam logic REG_CAPACITY = 1'b0;

    // Address width of a table of the given depth.
    function automatic int koet_aw(input int depth);
        koet_aw = (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // Width of a count that can reach the depth itself.
    function automatic int koet_cw(input int depth);
        koet_cw = $clog2(depth + 1);
    endfunction

endpackage

`default_nettype wire

[design/koet_store.sv]
// ----------------------------------------------------------------------------
// Keyed ordered entry table: entry store
// Single-port-write, single-port-read table of key/score entries with a
// registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module koet_store #(
    parameter int TABLE_DEPTH = koet_pkg::KOET_DEPTH
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_we,
    input  wire logic [koet_pkg::koet_aw(TABLE_DEPTH)-1:0]    i_waddr,
    input  wire logic [koet_pkg::ENTRY_W-1:0]                 i_wdata,
    input  wire logic [koet_pkg::koet_aw(TABLE_DEPTH)-1:0]    i_raddr,
    output logic      [koet_pkg::ENTRY_W-1:0]                 o_rdata
);
    import koet_pkg::*;

    logic [ENTRY_W-1:0] r_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[design/keyed_ordered_entry_table.sv]
// Append and rejected commands pass through the finish and output states to the result register.
// Set, get, find and count walk the table from position 0, one entry per cycle
// through the store's read port; remove walks from the given position to the end.
// A new request is taken only in the idle state, after the result is registered;
// the output state waits while an earlier result has not been taken.
// Reset is synchronous: table empty, capacity 64; the store is not cleared.
// ----------------------------------------------------------------------------
// Keyed ordered entry table
// Ordered table of key/score entries with append, set, get, remove, find and
// blank count commands, worked by a sequencer over the store's write and read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_ordered_entry_table #(
    parameter int TABLE_DEPTH = koet_pkg::KOET_DEPTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Command stream
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // [7:0] key_char, [23:8] new_score, [29:24] position, [31:30] zero
    input  wire logic [koet_pkg::S_DATA_W-1:0]     i_s_tdata,
    // [2:0] command
    input  wire logic [koet_pkg::CMD_W-1:0]        i_s_tuser,
    // Result stream
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // [7:0] out_key, [23:8] out_score, [29:24] out_position,
    // [36:30] blank_total, [43:37] fill_level, [47:44] zero
    output logic      [koet_pkg::M_DATA_W-1:0]     o_m_tdata,
    // [0] ok
    output logic                                   o_m_tuser,
    // Configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [koet_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [koet_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [koet_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);
    import koet_pkg::*;

    localparam int AW = koet_aw(TABLE_DEPTH);
    localparam int CW = koet_cw(TABLE_DEPTH);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]          r_state, n_state;
    logic [CAP_W-1:0]    r_cap;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [SCORE_W-1:0]  r_score, n_score;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic                r_push, n_push;
    logic [CW-1:0]       r_ridx, n_ridx;
    logic                r_pv, n_pv;
    logic [AW-1:0]       r_pidx, n_pidx;
    logic                r_ok, n_ok;
    logic [KEY_W-1:0]    r_okey, n_okey;
    logic [SCORE_W-1:0]  r_oscore, n_oscore;
    logic [AW-1:0]       r_opos, n_opos;
    logic [CW-1:0]       r_blank, n_blank;
    logic                r_m_tvalid, n_m_tvalid;
    logic [M_DATA_W-1:0] r_m_tdata, n_m_tdata;
    logic                r_m_tuser, n_m_tuser;

    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [ENTRY_W-1:0]  w_wdata;
    logic [AW-1:0]       w_raddr;
    logic [ENTRY_W-1:0]  w_rdata;
    logic [KEY_W-1:0]    w_rd_key;
    logic [SCORE_W-1:0]  w_rd_score;
    logic                w_accept;
    logic                w_room;
    logic                w_more;
    logic                w_drained;
    logic                w_hit;
    logic                w_cfg_wr;

    koet_store #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_key   = w_rdata[ENTRY_W-1:SCORE_W];
    assign w_rd_score = w_rdata[SCORE_W-1:0];

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_room    = (LW'(r_cnt) < LW'(r_cap)) && (r_cnt < CW'(TABLE_DEPTH));
    assign w_more    = (r_ridx < r_cnt);
    // Every entry has been read and its data already examined.
    assign w_drained = !r_pv && !w_more;
    assign w_hit     = r_pv && (w_rd_key == r_key);
    assign w_raddr   = r_ridx[AW-1:0];

    // Configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_CAPACITY) begin
            prdata = APB_DATA_W'(r_cap);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (w_cfg_wr && (paddr[2] == REG_CAPACITY)) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_cmd      = r_cmd;
        n_key      = r_key;
        n_score    = r_score;
        n_pos      = r_pos;
        n_push     = r_push;
        n_ridx     = r_ridx;
        n_pv       = 1'b0;
        n_pidx     = r_pidx;
        n_ok       = r_ok;
        n_okey     = r_okey;
        n_oscore   = r_oscore;
        n_opos     = r_opos;
        n_blank    = r_blank;
        n_m_tvalid = r_m_tvalid && !i_m_tready;
        n_m_tdata  = r_m_tdata;
        n_m_tuser  = r_m_tuser;
        w_we       = 1'b0;
        w_waddr    = r_pidx;
        w_wdata    = {r_key, r_score};

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd    = i_s_tuser;
                    n_key    = i_s_tdata[KEY_W-1:0];
                    n_score  = i_s_tdata[KEY_W+SCORE_W-1:KEY_W];
                    n_pos    = i_s_tdata[KEY_W+SCORE_W+POS_W-1:KEY_W+SCORE_W];
                    n_push   = 1'b0;
                    n_ridx   = '0;
                    n_ok     = 1'b0;
                    n_okey   = '0;
                    n_oscore = '0;
                    n_opos   = '0;
                    n_blank  = '0;
                    n_state  = S_FIN;
                    case (i_s_tuser) inside
                        CMD_APPEND: begin
                            n_push = 1'b1;
                        end
                        CMD_SET, CMD_GET, CMD_FIND: begin
                            n_state = S_SCAN;
                        end
                        CMD_COUNT: begin
                            n_ok    = 1'b1;
                            n_state = S_SCAN;
                        end
                        CMD_REMOVE: begin
                            if (PW'(i_s_tdata[KEY_W+SCORE_W+POS_W-1:KEY_W+SCORE_W])
                                    < PW'(r_cnt)) begin
                                n_ridx  = CW'(i_s_tdata[KEY_W+SCORE_W+POS_W-1:
                                                        KEY_W+SCORE_W]);
                                n_state = S_SHIFT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (r_cmd == CMD_COUNT) begin
                    if (r_pv && (w_rd_key == BLANK_KEY)) begin
                        n_blank = r_blank + 1'b1;
                    end
                    if (w_drained) begin
                        n_state = S_FIN;
                    end else if (w_more) begin
                        n_pv   = 1'b1;
                        n_pidx = r_ridx[AW-1:0];
                        n_ridx = r_ridx + 1'b1;
                    end
                end else if (w_hit) begin
                    n_ok    = 1'b1;
                    n_state = S_FIN;
                    case (r_cmd)
                        CMD_SET: begin
                            w_we = 1'b1;
                        end
                        CMD_GET: begin
                            n_oscore = w_rd_score;
                        end
                        default: begin
                            n_opos = r_pidx;
                        end
                    endcase
                end else if (w_drained) begin
                    // A set that finds no match falls back to an append.
                    n_push  = (r_cmd == CMD_SET);
                    n_state = S_FIN;
                end else if (w_more) begin
                    n_pv   = 1'b1;
                    n_pidx = r_ridx[AW-1:0];
                    n_ridx = r_ridx + 1'b1;
                end
            end

            S_SHIFT: begin
                // The entry at the removal point is returned; each later one
                // moves down a place as it comes out of the store.
                if (r_pv) begin
                    if (PW'(r_pidx) == PW'(r_pos)) begin
                        n_okey   = w_rd_key;
                        n_oscore = w_rd_score;
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = r_pidx - 1'b1;
                        w_wdata = w_rdata;
                    end
                end
                if (w_drained) begin
                    n_cnt   = r_cnt - 1'b1;
                    n_ok    = 1'b1;
                    n_state = S_FIN;
                end else if (w_more) begin
                    n_pv   = 1'b1;
                    n_pidx = r_ridx[AW-1:0];
                    n_ridx = r_ridx + 1'b1;
                end
            end

            S_FIN: begin
                if (r_push) begin
                    n_push = 1'b0;
                    if (w_room) begin
                        w_we    = 1'b1;
                        w_waddr = r_cnt[AW-1:0];
                        n_cnt   = r_cnt + 1'b1;
                        n_ok    = 1'b1;
                    end
                end
                n_state = S_OUT;
            end

            S_OUT: begin
                if (!r_m_tvalid || i_m_tready) begin
                    n_m_tvalid = 1'b1;
                    n_m_tuser  = r_ok;
                    n_m_tdata  = {4'd0, TOTAL_W'(r_cnt), TOTAL_W'(r_blank),
                                  POS_W'(r_opos), r_oscore, r_okey};
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_push     <= 1'b0;
            r_pv       <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_push     <= n_push;
            r_pv       <= n_pv;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_key     <= n_key;
        r_score   <= n_score;
        r_pos     <= n_pos;
        r_ridx    <= n_ridx;
        r_pidx    <= n_pidx;
        r_ok      <= n_ok;
        r_okey    <= n_okey;
        r_oscore  <= n_oscore;
        r_opos    <= n_opos;
        r_blank   <= n_blank;
        r_m_tdata <= n_m_tdata;
        r_m_tuser <= n_m_tuser;
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

endmodule

`default_nettype wire
